>>> rtl/kbl_pkg.sv
// Shared types and constants for the K-line block link engine.
// Used by kbl_link and kline_block_link_engine; depends on nothing.
`default_nettype none

package kbl_pkg;

  typedef enum logic [1:0] {
    FUNC_LINE_RX  = 2'd0,
    FUNC_HOST_TX  = 2'd1,
    FUNC_START_RX = 2'd2,
    FUNC_TICK     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OK      = 3'd1,
    EV_DONE    = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_BADCOMP = 3'd4,
    EV_BADCNT  = 3'd5,
    EV_SIZE    = 3'd6,
    EV_BUSY    = 3'd7
  } event_e;

  localparam logic [15:0] TimeoutTicksReset = 16'd1000;
  localparam logic [7:0]  FillByte          = 8'hFF;
  localparam logic [15:0] TickSat           = 16'hFFFF;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] expected_size;
    logic [7:0] max_size;
  } item_t;

  typedef struct packed {
    logic       has_result;
    logic       line_tx_valid;
    logic [7:0] line_tx_byte;
    logic       host_rx_valid;
    logic [7:0] host_rx_byte;
    event_e     event_code;
    logic [7:0] block_count;
    logic [7:0] timeout_errors;
    logic [7:0] data_errors;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/kline_block_link_engine.sv
// Top level of the K-line block link engine: request register, config
// register and result register around kbl_link. Depends on kbl_pkg, kbl_link.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_ready_o   func, data_byte, last_byte,
//                                                expected_size, max_size
//   out       source     out_valid_o/out_ready_i line_tx/host_rx, event_code,
//                                                block_count, error counts
//   cfg       sink       cfg_valid_i/cfg_ready_o timeout_ticks (always ready)
//
// One request per cycle while out_ready_i is high; the result is registered.
// The link state update is one pass of logic between request and result regs.
// Reset (async, low) clears link state, counters; timeout_ticks resets to 1000.
// A stalled result blocks only the request register; one more request is held.
`default_nettype none

module kline_block_link_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [7:0]  expected_size_i,
  input  wire logic [7:0]  max_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             line_tx_valid_o,
  output logic [7:0]       line_tx_byte_o,
  output logic             host_rx_valid_o,
  output logic [7:0]       host_rx_byte_o,
  output logic [2:0]       event_code_o,
  output logic [7:0]       block_count_o,
  output logic [7:0]       timeout_errors_o,
  output logic [7:0]       data_errors_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_timeout_ticks_i
);
  import kbl_pkg::*;

  logic        in_valid_q;
  item_t       item_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     res;
  logic [15:0] timeout_ticks_q;
  logic        advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= TimeoutTicksReset;
    end else if (cfg_valid_i) begin
      timeout_ticks_q <= cfg_timeout_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func          <= func_e'(func_i);
      item_q.data_byte     <= data_byte_i;
      item_q.last_byte     <= last_byte_i;
      item_q.expected_size <= expected_size_i;
      item_q.max_size      <= max_size_i;
    end
  end

  kbl_link u_link (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .item_i         (item_q),
    .timeout_ticks_i(timeout_ticks_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.has_result) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign line_tx_valid_o  = out_q.line_tx_valid;
  assign line_tx_byte_o   = out_q.line_tx_byte;
  assign host_rx_valid_o  = out_q.host_rx_valid;
  assign host_rx_byte_o   = out_q.host_rx_byte;
  assign event_code_o     = out_q.event_code;
  assign block_count_o    = out_q.block_count;
  assign timeout_errors_o = out_q.timeout_errors;
  assign data_errors_o    = out_q.data_errors;

  a_stall_holds_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o && !advance)
    else $error("request advanced into a stalled result register");

  a_rx_byte_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && host_rx_valid_o |-> event_code_o == EV_OK || event_code_o == EV_DONE)
    else $error("delivered byte with an error event");

  a_tx_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_tx_valid_o |-> line_tx_byte_o == 8'h00)
    else $error("line byte not cleared without transmit");

endmodule

`default_nettype wire

>>> rtl/kbl_link.sv
// Link state and per-request update logic of the K-line block link engine.
// Depends on kbl_pkg; instantiated by kline_block_link_engine.
`default_nettype none

module kbl_link (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  kbl_pkg::item_t       item_i,
  input  wire logic [15:0]     timeout_ticks_i,
  output kbl_pkg::result_t     res_o
);
  import kbl_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECV = 2'd1,
    MODE_SEND = 2'd2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  block_counter_q, block_counter_d;
  logic [8:0]  size_expected_q, size_expected_d;
  logic [7:0]  size_limit_q, size_limit_d;
  logic [8:0]  bytes_seen_q, bytes_seen_d;
  logic        length_mode_q, length_mode_d;
  logic [7:0]  comp_wanted_q, comp_wanted_d;
  logic        awaiting_q, awaiting_d;
  logic [15:0] idle_ticks_q, idle_ticks_d;
  logic [7:0]  timeout_cnt_q, timeout_cnt_d;
  logic [7:0]  data_err_q, data_err_d;

  always_comb begin
    logic [7:0]  d;
    logic [8:0]  bs_n;
    logic [8:0]  se_n;
    logic [15:0] it_n;
    logic        go_idle;
    d       = item_i.data_byte;
    bs_n    = bytes_seen_q + 9'd1;
    se_n    = size_expected_q;
    it_n    = (idle_ticks_q == TickSat) ? idle_ticks_q : idle_ticks_q + 16'd1;
    go_idle = 1'b0;

    mode_d          = mode_q;
    block_counter_d = block_counter_q;
    size_expected_d = size_expected_q;
    size_limit_d    = size_limit_q;
    bytes_seen_d    = bytes_seen_q;
    length_mode_d   = length_mode_q;
    comp_wanted_d   = comp_wanted_q;
    awaiting_d      = awaiting_q;
    idle_ticks_d    = idle_ticks_q;
    timeout_cnt_d   = timeout_cnt_q;
    data_err_d      = data_err_q;

    res_o               = '0;
    res_o.event_code    = EV_NONE;

    case (item_i.func)
      FUNC_LINE_RX: begin
        if (d != FillByte) begin
          if (mode_q == MODE_SEND) begin
            if (awaiting_q) begin
              res_o.has_result = 1'b1;
              if (d == comp_wanted_q) begin
                awaiting_d       = 1'b0;
                idle_ticks_d     = '0;
                res_o.event_code = EV_OK;
              end else begin
                data_err_d       = data_err_q + 8'd1;
                go_idle          = 1'b1;
                res_o.event_code = EV_BADCOMP;
              end
            end
          end else if (mode_q == MODE_RECV) begin
            res_o.has_result = 1'b1;
            bytes_seen_d     = bs_n;
            idle_ticks_d     = '0;
            if (length_mode_q && bs_n == 9'd1) begin
              se_n            = {1'b0, d} + 9'd1;
              size_expected_d = se_n;
            end
            if (length_mode_q && bs_n == 9'd1 && se_n > {1'b0, size_limit_q}) begin
              go_idle          = 1'b1;
              res_o.event_code = EV_SIZE;
            end else if (length_mode_q && bs_n == 9'd2 && d != block_counter_q) begin
              data_err_d       = data_err_q + 8'd1;
              go_idle          = 1'b1;
              res_o.event_code = EV_BADCNT;
            end else begin
              // length mode acks all but the last byte, fixed mode only the last
              res_o.line_tx_valid = length_mode_q ? (bs_n < se_n) : (bs_n == se_n);
              res_o.line_tx_byte  = res_o.line_tx_valid ? ~d : 8'h00;
              res_o.host_rx_valid = 1'b1;
              res_o.host_rx_byte  = d;
              res_o.event_code    = EV_OK;
              if (bs_n >= se_n) begin
                block_counter_d  = block_counter_q + 8'd1;
                go_idle          = 1'b1;
                res_o.event_code = EV_DONE;
              end
            end
          end
        end
      end
      FUNC_HOST_TX: begin
        res_o.has_result = 1'b1;
        if (mode_q == MODE_RECV || (mode_q == MODE_SEND && awaiting_q)) begin
          res_o.event_code = EV_BUSY;
        end else begin
          res_o.line_tx_valid = 1'b1;
          res_o.line_tx_byte  = d;
          if (item_i.last_byte) begin
            block_counter_d  = block_counter_q + 8'd1;
            go_idle          = 1'b1;
            res_o.event_code = EV_DONE;
          end else begin
            mode_d           = MODE_SEND;
            comp_wanted_d    = ~d;
            awaiting_d       = 1'b1;
            idle_ticks_d     = '0;
            res_o.event_code = EV_OK;
          end
        end
      end
      FUNC_START_RX: begin
        if (mode_q == MODE_RECV || mode_q == MODE_SEND) begin
          res_o.has_result = 1'b1;
          res_o.event_code = EV_BUSY;
        end else if (item_i.expected_size > item_i.max_size) begin
          res_o.has_result = 1'b1;
          go_idle          = 1'b1;
          res_o.event_code = EV_SIZE;
        end else begin
          mode_d          = MODE_RECV;
          size_expected_d = {1'b0, item_i.expected_size};
          size_limit_d    = item_i.max_size;
          length_mode_d   = (item_i.expected_size == 8'd0);
          bytes_seen_d    = '0;
          awaiting_d      = 1'b0;
          idle_ticks_d    = '0;
        end
      end
      FUNC_TICK: begin
        if (mode_q == MODE_RECV || (mode_q == MODE_SEND && awaiting_q)) begin
          idle_ticks_d = it_n;
          if (it_n >= timeout_ticks_i) begin
            res_o.has_result = 1'b1;
            timeout_cnt_d    = timeout_cnt_q + 8'd1;
            go_idle          = 1'b1;
            res_o.event_code = EV_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase

    if (go_idle) begin
      mode_d       = MODE_IDLE;
      awaiting_d   = 1'b0;
      idle_ticks_d = '0;
    end

    res_o.block_count    = block_counter_d;
    res_o.timeout_errors = timeout_cnt_d;
    res_o.data_errors    = data_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_IDLE;
      block_counter_q <= '0;
      size_expected_q <= '0;
      size_limit_q    <= '0;
      bytes_seen_q    <= '0;
      length_mode_q   <= 1'b0;
      comp_wanted_q   <= '0;
      awaiting_q      <= 1'b0;
      idle_ticks_q    <= '0;
      timeout_cnt_q   <= '0;
      data_err_q      <= '0;
    end else if (fire_i) begin
      mode_q          <= mode_d;
      block_counter_q <= block_counter_d;
      size_expected_q <= size_expected_d;
      size_limit_q    <= size_limit_d;
      bytes_seen_q    <= bytes_seen_d;
      length_mode_q   <= length_mode_d;
      comp_wanted_q   <= comp_wanted_d;
      awaiting_q      <= awaiting_d;
      idle_ticks_q    <= idle_ticks_d;
      timeout_cnt_q   <= timeout_cnt_d;
      data_err_q      <= data_err_d;
    end
  end

  a_await_only_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> mode_q == MODE_SEND)
    else $error("complement pending outside send mode");

  a_idle_no_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> idle_ticks_q == 16'd0)
    else $error("tick count left running in idle");

  a_errors_keep_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (res_o.event_code == EV_TIMEOUT || res_o.event_code == EV_BADCOMP ||
               res_o.event_code == EV_BADCNT || res_o.event_code == EV_SIZE)
    |=> $stable(block_counter_q))
    else $error("error changed the block counter");

endmodule

`default_nettype wire
